[design/sptm_pkg.sv]
package sptm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STEPS    = 24;
   localparam int STEP_COUNT   = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int STEP_W       = $clog2(MAX_STEPS);

   localparam int RANGE_W = 26;
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 32;
   localparam int GAIN_W  = 30;
   localparam int PROD_W  = RANGE_W + GAIN_W;
   localparam int SCALE_W = PROD_W - 22;
   localparam int CW      = SCALE_W + 3;
   localparam int ZW      = 34;
   localparam int ATAN_W  = 30;
   localparam int OFF_W   = CW - 8;
   localparam int SUM_W   = POS_W + 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]  INV_GAIN        = 30'd652032874;
   localparam logic [RANGE_W-1:0] INVALID_RANGE   = 26'd655360;
   localparam logic [RANGE_W-1:0] START_MIN_RANGE = 26'd65536000;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_X       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_Y       = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_INIT,
      S_ROT,
      S_OUT
   } state_type;

   function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[design/scan_points_to_map_frame.sv]
// Converts laser range samples into map-frame points, one sample per transfer.
// The request channel carries the range, its valid flag and the scan start
// marker; the response channel returns the rotated and offset point together
// with the closest point and range seen so far in the current scan.
// Each item is worked by one shared CORDIC rotator that performs one
// micro-rotation per cycle. An item passes through the gain multiply, quadrant
// folding, STEP_COUNT rotation steps and a final step that offsets, saturates
// and loads the result register; only after that is the next request taken.
// The result register drives the response channel. req_stall is high while
// an item is in work.
// If the response side stalls, the finished result waits in the output
// register and the next item may be taken and rotated; it then waits in the
// final step until the output register is free.
// The csr port is always ready; registers should be written only while idle.
// Reset clears the registers, the beam angle and the closest point, and sets
// the running minimum to 1000 m.
module scan_points_to_map_frame (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sptm_pkg::RANGE_W-1:0]       req_range_sample,
   input  logic                               req_range_valid,
   input  logic                               req_scan_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [sptm_pkg::POS_W-1:0]  rsp_point_x,
   output logic signed [sptm_pkg::POS_W-1:0]  rsp_point_y,
   output logic signed [sptm_pkg::POS_W-1:0]  rsp_closest_x,
   output logic signed [sptm_pkg::POS_W-1:0]  rsp_closest_y,
   output logic [sptm_pkg::RANGE_W-1:0]       rsp_closest_range,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sptm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sptm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sptm_pkg::*;

   state_type state_ff, state_in;

   logic [ANGLE_W-1:0] start_angle_ff, angle_step_ff, heading_ff;
   logic signed [POS_W-1:0] robot_x_ff, robot_y_ff;

   logic [ANGLE_W-1:0] beam_angle_ff, beam_angle_in;
   logic [RANGE_W-1:0] min_range_ff, min_range_in;
   logic signed [POS_W-1:0] nearest_x_ff, nearest_x_in, nearest_y_ff, nearest_y_in;

   logic [RANGE_W-1:0] range_ff, range_in;
   logic [ANGLE_W-1:0] theta_ff, theta_in;
   logic               start_ff, start_in;
   logic [SCALE_W-1:0] scaled_ff, scaled_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic signed [POS_W-1:0] point_x_ff, point_x_in, point_y_ff, point_y_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [PROD_W-1:0]     product;
   logic [ANGLE_W-1:0]    ang_sel;
   logic                  quad_flip;
   logic signed [ANGLE_W-1:0] z_fold;
   logic signed [CW-1:0]  x_shift, y_shift;
   logic signed [ZW-1:0]  atan_val;
   logic signed [CW-1:0]  x_round, y_round;
   logic signed [OFF_W-1:0] off_x, off_y;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [POS_W-1:0] sat_x, sat_y;
   logic [RANGE_W-1:0]    cur_min;
   logic                  req_take, out_load;

   function automatic logic signed [POS_W-1:0] saturate(input logic signed [SUM_W-1:0] s);
      logic signed [POS_W-1:0] r;
      if (s[SUM_W-1:POS_W-1] == '0 || s[SUM_W-1:POS_W-1] == '1) begin
         r = s[POS_W-1:0];
      end else if (s[SUM_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         heading_ff     <= '0;
         robot_x_ff     <= '0;
         robot_y_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_ANGLE:   start_angle_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_ANGLE_STEP:    angle_step_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_ROBOT_HEADING: heading_ff     <= csr_wdata[ANGLE_W-1:0];
            CSR_ROBOT_X:       robot_x_ff     <= csr_wdata[POS_W-1:0];
            CSR_ROBOT_Y:       robot_y_ff     <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign product   = {{GAIN_W{1'b0}}, range_ff} * {{RANGE_W{1'b0}}, INV_GAIN};
   assign ang_sel   = req_scan_start ? start_angle_ff : beam_angle_ff;
   assign quad_flip = theta_ff[ANGLE_W-1] ^ theta_ff[ANGLE_W-2];
   assign z_fold    = quad_flip ? {~theta_ff[ANGLE_W-1], theta_ff[ANGLE_W-2:0]} : theta_ff;

   assign x_shift  = x_ff >>> step_ff;
   assign y_shift  = y_ff >>> step_ff;
   assign atan_val = ZW'(atan_entry(step_ff));

   assign x_round = x_ff + CW'(128);
   assign y_round = y_ff + CW'(128);
   assign off_x   = x_round[CW-1:8];
   assign off_y   = y_round[CW-1:8];
   assign sum_x   = SUM_W'(robot_x_ff) + SUM_W'(off_x);
   assign sum_y   = SUM_W'(robot_y_ff) + SUM_W'(off_y);
   assign sat_x   = saturate(sum_x);
   assign sat_y   = saturate(sum_y);
   assign cur_min = start_ff ? START_MIN_RANGE : min_range_ff;

   always_comb begin
      state_in      = state_ff;
      beam_angle_in = beam_angle_ff;
      min_range_in  = min_range_ff;
      nearest_x_in  = nearest_x_ff;
      nearest_y_in  = nearest_y_ff;
      range_in      = range_ff;
      theta_in      = theta_ff;
      start_in      = start_ff;
      scaled_in     = scaled_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      step_in       = step_ff;
      point_x_in    = point_x_ff;
      point_y_in    = point_y_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               range_in      = req_range_valid ? req_range_sample : INVALID_RANGE;
               theta_in      = ang_sel + heading_ff;
               start_in      = req_scan_start;
               beam_angle_in = ang_sel + angle_step_ff;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            scaled_in = product[PROD_W-1:22];
            state_in  = S_INIT;
         end
         S_INIT: begin
            x_in     = quad_flip ? -CW'(scaled_ff) : CW'(scaled_ff);
            y_in     = '0;
            z_in     = {{(ZW-ANGLE_W-16){z_fold[ANGLE_W-1]}}, z_fold, 16'd0};
            step_in  = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_val;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEP_COUNT - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               point_x_in   = sat_x;
               point_y_in   = sat_y;
               rsp_valid_in = 1'b1;
               min_range_in = cur_min;
               if (range_ff < cur_min) begin
                  min_range_in = range_ff;
                  nearest_x_in = sat_x;
                  nearest_y_in = sat_y;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         beam_angle_ff <= '0;
         min_range_ff  <= START_MIN_RANGE;
         nearest_x_ff  <= '0;
         nearest_y_ff  <= '0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         beam_angle_ff <= beam_angle_in;
         min_range_ff  <= min_range_in;
         nearest_x_ff  <= nearest_x_in;
         nearest_y_ff  <= nearest_y_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff   <= range_in;
      theta_ff   <= theta_in;
      start_ff   <= start_in;
      scaled_ff  <= scaled_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_x       = point_x_ff;
   assign rsp_point_y       = point_y_ff;
   assign rsp_closest_x     = nearest_x_ff;
   assign rsp_closest_y     = nearest_y_ff;
   assign rsp_closest_range = min_range_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output step");

   a_take_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_MUL)
      else $error("request transfer did not start the multiply");

   a_closest_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(min_range_ff) && $stable(nearest_x_ff))
      else $error("closest point changed under a stalled response");

   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      min_range_ff <= START_MIN_RANGE)
      else $error("running minimum above its scan start value");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROT |-> step_ff < STEP_W'(STEP_COUNT))
      else $error("rotation step counter out of range");

endmodule
